FILE: sv/assert_macros.svh
// assertion macros used by the top rtl file of the packet framer
// no dependencies; taken in by plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mqpf_pkg.sv
// shared types, codes and byte constants of the mqtt packet framer
// no dependencies; imported by every module of the block
`default_nettype none

package mqpf_pkg;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // configuration registers
    localparam logic       REG_MAX_LEN   = 1'b0;
    localparam logic       REG_CLIENT_ID = 1'b1;
    localparam logic [15:0] MAX_LEN_RST   = 16'd255;
    localparam logic [47:0] CLIENT_ID_RST = 48'h414243444546;

    // request and packet codes
    localparam logic REQ_BEGIN   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;
    localparam logic PKT_CONNECT = 1'b0;
    localparam logic PKT_PUBLISH = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_MAX_LEN = 2'd1;
    localparam logic [1:0] ERR_REM_LEN = 2'd2;

    // command opcodes passed from front to back
    localparam logic [1:0] OP_ERR  = 2'd0;
    localparam logic [1:0] OP_CONN = 2'd1;
    localparam logic [1:0] OP_PUB  = 2'd2;
    localparam logic [1:0] OP_DATA = 2'd3;

    // packet byte constants
    localparam logic [7:0]  HDR_CONNECT   = 8'h10;
    localparam logic [7:0]  HDR_PUBLISH   = 8'h30;
    localparam logic [7:0]  NAME_LEN      = 8'h06;
    localparam logic [47:0] PROTO_NAME    = 48'h4D5149736470;
    localparam logic [7:0]  PROTO_LEVEL   = 8'h03;
    localparam logic [7:0]  CONNECT_FLAGS = 8'hC2;
    localparam logic [7:0]  KEEPALIVE_LO  = 8'h3C;
    localparam logic [7:0]  CLIENT_ID_LEN = 8'h06;

    // fixed byte counts, length prefix included
    localparam logic [4:0] CONN_BODY_LEN = 5'd24;
    localparam logic [4:0] PUB_BODY_LEN  = 5'd4;
    localparam logic [4:0] ONE_BYTE_LEN  = 5'd1;
    localparam logic [4:0] PFX_LEN       = 5'd2;

    // one unit of work for the back sequencer
    typedef struct packed {
        logic [1:0] op;     // opcode
        logic [7:0] data;   // remaining length or payload byte
        logic [7:0] a;      // first field length
        logic [7:0] b;      // second field length
        logic [1:0] err;    // error code on error commands
        logic       pfx;    // append the password length prefix
        logic       last;   // final byte of this command ends the packet
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: sv/mqtt_packet_framer.sv
// MQTT 3.1 CONNECT / PUBLISH packet framer. A begin beat (tuser[0] = 0) gives the
// packet kind and two field lengths; the front checks the packet size against
// max_len and the remaining length against 255 in the cycle it takes the beat,
// then queues one command. The back sequencer plays commands out one byte per
// cycle while the output is not stalled, into a registered output: 4 header
// bytes for PUBLISH, 24 for CONNECT (26 when the username is empty, with the
// password length prefix), one zero byte for an error result. A payload beat
// gives one byte, 3 for the last username byte of a CONNECT. The front takes
// one beat per cycle until the QUEUE_DEPTH-entry command queue fills. Payload
// beats with no packet open are dropped. Configure only while idle.
`default_nettype none
`include "assert_macros.svh"

module mqtt_packet_framer #(
    parameter int QUEUE_DEPTH = mqpf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [mqpf_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // first_len, second_len, payload_byte
    input  wire logic [mqpf_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,  // req_type, packet_kind
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [mqpf_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,  // out_byte
    output logic                                 o_m_axis_tlast,
    output logic [mqpf_pkg::M_TUSER_W-1:0]       o_m_axis_tuser,  // error
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_index,
    input  wire logic [47:0]                     i_cfg_data
);
    import mqpf_pkg::*;

    logic [15:0] r_max_len;
    logic [47:0] r_client_id;
    logic        cfg_write;

    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RST;
            r_client_id <= CLIENT_ID_RST;
        end else if (cfg_write) begin
            if (i_cfg_index == REG_MAX_LEN) begin
                r_max_len <= i_cfg_data[15:0];
            end else begin
                r_client_id <= i_cfg_data;
            end
        end
    end

    // front: accept and classify
    mqpf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_user    (i_s_axis_tuser),
        .i_max_len (r_max_len),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    // command queue
    mqpf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    // back: byte sequencer and output register
    mqpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .i_client_id (r_client_id),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_user      (o_m_axis_tuser)
    );

    // checks
    `ASSERT_IMPLY(a_err_beat_shape, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser != ERR_NONE),
        o_m_axis_tlast && (o_m_axis_tdata == 8'h00),
        "error beat must be last with a zero byte")
    `ASSERT_IMPLY(a_err_code_known, i_clk, i_rst_n,
        o_m_axis_tvalid,
        (o_m_axis_tuser == ERR_NONE) || (o_m_axis_tuser == ERR_MAX_LEN) ||
        (o_m_axis_tuser == ERR_REM_LEN),
        "unknown error code on output")
    `ASSERT_NEXT(a_max_len_load, i_clk, i_rst_n,
        cfg_write && (i_cfg_index == REG_MAX_LEN),
        r_max_len == $past(i_cfg_data[15:0]),
        "max_len write not applied")

endmodule

`default_nettype wire

FILE: sv/mqpf_fifo.sv
// command queue between the framer front and back sequencer
// depends on mqpf_pkg for the command and status types
`default_nettype none

module mqpf_fifo #(
    parameter int DEPTH = mqpf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  mqpf_pkg::t_cmd        i_cmd,
    input  wire logic             i_pop,
    output mqpf_pkg::t_cmd        o_cmd,
    output mqpf_pkg::t_q_stat     o_stat
);
    import mqpf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/mqpf_front.sv
// front of the packet framer: accepts input beats, checks lengths,
// tracks the open packet and queues commands; depends on mqpf_pkg
`default_nettype none

module mqpf_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [mqpf_pkg::S_TDATA_W-1:0]  i_data,  // first_len, second_len, payload_byte
    input  wire logic [mqpf_pkg::S_TUSER_W-1:0]  i_user,  // req_type, packet_kind
    input  wire logic [15:0]                     i_max_len,
    input  mqpf_pkg::t_q_stat                    i_q_stat,
    output logic                                 o_push,
    output mqpf_pkg::t_cmd                       o_cmd
);
    import mqpf_pkg::*;

    // open packet codes
    localparam logic [1:0] KIND_IDLE    = 2'd0;
    localparam logic [1:0] KIND_CONNECT = 2'd1;
    localparam logic [1:0] KIND_PUBLISH = 2'd2;

    logic [1:0] r_open_kind, n_open_kind;
    logic       r_phase, n_phase;
    logic [7:0] r_left, n_left;
    logic [7:0] r_held, n_held;

    logic       accept;
    logic       req;
    logic       kind;
    logic [7:0] first_len;
    logic [7:0] second_len;
    logic [7:0] payload;
    logic [9:0] total;
    logic [9:0] rem;

    assign o_ready    = !i_q_stat.full;
    assign accept     = i_valid && o_ready;
    assign req        = i_user[0];
    assign kind       = i_user[1];
    assign first_len  = i_data[7:0];
    assign second_len = i_data[15:8];
    assign payload    = i_data[23:16];

    // packet size and remaining length
    assign total = {2'b00, first_len} + {2'b00, second_len}
                 + ((kind == PKT_CONNECT) ? 10'd26 : 10'd4);
    assign rem   = total - 10'd2;

    // classify the beat and build its command
    always_comb begin
        n_open_kind = r_open_kind;
        n_phase     = r_phase;
        n_left      = r_left;
        n_held      = r_held;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (accept) begin
            if (req == REQ_BEGIN) begin
                o_push = 1'b1;
                if ({6'd0, total} > i_max_len || total > 10'd257) begin
                    // length error: one error result, packet closed
                    o_cmd.op    = OP_ERR;
                    o_cmd.err   = ({6'd0, total} > i_max_len) ? ERR_MAX_LEN : ERR_REM_LEN;
                    o_cmd.last  = 1'b1;
                    n_open_kind = KIND_IDLE;
                    n_phase     = 1'b0;
                    n_left      = '0;
                    n_held      = '0;
                end else begin
                    o_cmd.op   = (kind == PKT_CONNECT) ? OP_CONN : OP_PUB;
                    o_cmd.data = rem[7:0];
                    o_cmd.a    = first_len;
                    o_cmd.b    = second_len;
                    o_cmd.pfx  = (kind == PKT_CONNECT) && (first_len == '0);
                    o_cmd.last = (first_len == '0) && (second_len == '0);
                    n_open_kind = (kind == PKT_CONNECT) ? KIND_CONNECT : KIND_PUBLISH;
                    n_held      = second_len;
                    if (first_len != '0) begin
                        n_phase = 1'b0;
                        n_left  = first_len;
                    end else if (second_len != '0) begin
                        n_phase = 1'b1;
                        n_left  = second_len;
                    end else begin
                        n_open_kind = KIND_IDLE;
                        n_phase     = 1'b0;
                        n_left      = '0;
                        n_held      = '0;
                    end
                end
            end else if (r_open_kind != KIND_IDLE) begin
                // payload byte of the open packet
                o_push     = 1'b1;
                o_cmd.op   = OP_DATA;
                o_cmd.data = payload;
                o_cmd.b    = r_held;
                if (r_left <= 8'd1) begin
                    n_left = '0;
                    if (!r_phase && r_held != '0) begin
                        o_cmd.pfx = (r_open_kind == KIND_CONNECT);
                        n_phase   = 1'b1;
                        n_left    = r_held;
                    end else begin
                        o_cmd.pfx   = !r_phase && (r_open_kind == KIND_CONNECT);
                        o_cmd.last  = 1'b1;
                        n_open_kind = KIND_IDLE;
                        n_phase     = 1'b0;
                        n_held      = '0;
                    end
                end else begin
                    n_left = r_left - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_kind <= KIND_IDLE;
            r_phase     <= 1'b0;
            r_left      <= '0;
            r_held      <= '0;
        end else begin
            r_open_kind <= n_open_kind;
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_held      <= n_held;
        end
    end

endmodule

`default_nettype wire

FILE: sv/mqpf_back.sv
// back of the packet framer: expands queued commands into output bytes,
// one byte per cycle while the output is not stalled, into an output register; depends on mqpf_pkg
`default_nettype none

module mqpf_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  mqpf_pkg::t_cmd                       i_cmd,
    input  mqpf_pkg::t_q_stat                    i_q_stat,
    output logic                                 o_pop,
    input  wire logic [47:0]                     i_client_id,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [mqpf_pkg::M_TDATA_W-1:0]       o_data,  // out_byte
    output logic                                 o_last,
    output logic [mqpf_pkg::M_TUSER_W-1:0]       o_user   // error
);
    import mqpf_pkg::*;

    t_cmd       r_cmd;
    logic       r_busy;
    logic [4:0] r_step;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [1:0] r_out_err;

    logic [4:0] body_len;
    logic [4:0] cmd_len;
    logic [7:0] body_byte;
    logic [7:0] cur_byte;
    logic       slot_free;
    logic       emit;
    logic       is_final;

    assign slot_free = !r_out_valid || i_ready;
    assign emit      = r_busy && slot_free;
    assign cmd_len   = body_len + (r_cmd.pfx ? PFX_LEN : 5'd0);
    assign is_final  = (r_step == cmd_len - 5'd1);
    assign o_pop     = !i_q_stat.empty && (!r_busy || (emit && is_final));

    // byte at the current step of the command
    always_comb begin
        body_byte = 8'h00;
        body_len  = ONE_BYTE_LEN;
        unique case (r_cmd.op)
            OP_CONN: begin
                body_len = CONN_BODY_LEN;
                unique case (r_step)
                    5'd0:    body_byte = HDR_CONNECT;
                    5'd1:    body_byte = r_cmd.data;
                    5'd3:    body_byte = NAME_LEN;
                    5'd4:    body_byte = PROTO_NAME[47:40];
                    5'd5:    body_byte = PROTO_NAME[39:32];
                    5'd6:    body_byte = PROTO_NAME[31:24];
                    5'd7:    body_byte = PROTO_NAME[23:16];
                    5'd8:    body_byte = PROTO_NAME[15:8];
                    5'd9:    body_byte = PROTO_NAME[7:0];
                    5'd10:   body_byte = PROTO_LEVEL;
                    5'd11:   body_byte = CONNECT_FLAGS;
                    5'd13:   body_byte = KEEPALIVE_LO;
                    5'd15:   body_byte = CLIENT_ID_LEN;
                    5'd16:   body_byte = i_client_id[47:40];
                    5'd17:   body_byte = i_client_id[39:32];
                    5'd18:   body_byte = i_client_id[31:24];
                    5'd19:   body_byte = i_client_id[23:16];
                    5'd20:   body_byte = i_client_id[15:8];
                    5'd21:   body_byte = i_client_id[7:0];
                    5'd23:   body_byte = r_cmd.a;
                    default: body_byte = 8'h00;
                endcase
            end
            OP_PUB: begin
                body_len = PUB_BODY_LEN;
                unique case (r_step)
                    5'd0:    body_byte = HDR_PUBLISH;
                    5'd1:    body_byte = r_cmd.data;
                    5'd3:    body_byte = r_cmd.a;
                    default: body_byte = 8'h00;
                endcase
            end
            OP_DATA: begin
                body_byte = r_cmd.data;
            end
            default: begin
                body_byte = 8'h00;
            end
        endcase
    end

    // password length prefix follows the body
    always_comb begin
        if (r_step == body_len + 5'd1) begin
            cur_byte = r_cmd.b;
        end else if (r_step == body_len) begin
            cur_byte = 8'h00;
        end else begin
            cur_byte = body_byte;
        end
    end

    // command sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (emit && is_final) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_step <= r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= is_final && r_cmd.last;
            r_out_err  <= (r_cmd.op == OP_ERR) ? r_cmd.err : ERR_NONE;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_user  = r_out_err;

endmodule

`default_nettype wire

FILE: tb/mqtt_packet_framer_checker.sv
`timescale 1ns / 1ps
// stream checker for the mqtt packet framer: predicts the encoded byte stream
// from accepted input and register beats and compares every output beat
// depends on mqpf_pkg for stream widths, codes and packet byte constants

module mqtt_packet_framer_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream as seen by the block
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [mqpf_pkg::S_TDATA_W-1:0]  i_s_tdata,  // first_len, second_len, payload_byte
    input  wire logic [mqpf_pkg::S_TUSER_W-1:0]  i_s_tuser,  // req_type, packet_kind
    // output stream of the block
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [mqpf_pkg::M_TDATA_W-1:0]  i_m_tdata,  // out_byte
    input  wire logic                            i_m_tlast,
    input  wire logic [mqpf_pkg::M_TUSER_W-1:0]  i_m_tuser,  // error
    // register writes
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic                            i_cfg_index,
    input  wire logic [47:0]                     i_cfg_data,
    // status for the testbench top
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_beats_out,
    output int                                   o_error_results
);
    import mqpf_pkg::*;

    // fixed byte counts of each packet kind, both fixed header bytes included
    localparam int CONNECT_FIXED = 26;
    localparam int PUBLISH_FIXED = 4;
    localparam int MAX_PRINTED   = 40;

    typedef enum logic [1:0] {
        OPEN_NONE,
        OPEN_CONNECT,
        OPEN_PUBLISH
    } t_open_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } t_frame_beat;

    // expected output beats, oldest first
    t_frame_beat frame_beats_q[$];
    t_frame_beat head;

    // bytes produced by the beat being predicted
    logic [7:0]  step_bytes[$];
    logic        step_closed;

    // mirrored block state and registers
    t_open_kind  open_kind;
    logic        field_phase;
    logic [7:0]  bytes_left;
    logic [7:0]  held_len;
    logic [15:0] max_len;
    logic [47:0] client_id;

    task automatic report(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic emit(input logic [7:0] value);
        step_bytes.push_back(value);
    endtask

    task automatic close_frame();
        open_kind   = OPEN_NONE;
        field_phase = 1'b0;
        bytes_left  = 8'd0;
        held_len    = 8'd0;
        step_closed = 1'b1;
    endtask

    // username or topic done: password prefix for connect, then second field
    task automatic end_first_field();
        if (open_kind == OPEN_CONNECT) begin
            emit(8'h00);
            emit(held_len);
        end
        if (held_len == 8'd0) begin
            close_frame();
        end else begin
            field_phase = 1'b1;
            bytes_left  = held_len;
        end
    endtask

    task automatic predict_beat(input logic req, input logic kind,
                                input logic [7:0] first_len, input logic [7:0] second_len,
                                input logic [7:0] pay);
        int unsigned total;
        logic [1:0]  err;
        step_bytes.delete();
        step_closed = 1'b0;
        if (req == REQ_BEGIN) begin
            total = ((kind == PKT_CONNECT) ? CONNECT_FIXED : PUBLISH_FIXED)
                    + first_len + second_len;
            if (total > max_len)
                err = ERR_MAX_LEN;
            else if (total - 2 > 255)
                err = ERR_REM_LEN;
            else
                err = ERR_NONE;
            if (err != ERR_NONE) begin
                // size check failed: one error beat, nothing written
                close_frame();
                frame_beats_q.push_back(t_frame_beat'{8'h00, 1'b1, err});
            end else begin
                if (kind == PKT_CONNECT) begin
                    emit(HDR_CONNECT);
                    emit(8'(total - 2));
                    emit(8'h00);
                    emit(NAME_LEN);
                    for (int i = 5; i >= 0; i--)
                        emit(PROTO_NAME[8*i +: 8]);
                    emit(PROTO_LEVEL);
                    emit(CONNECT_FLAGS);
                    emit(8'h00);
                    emit(KEEPALIVE_LO);
                    emit(8'h00);
                    emit(CLIENT_ID_LEN);
                    for (int i = 5; i >= 0; i--)
                        emit(client_id[8*i +: 8]);
                    open_kind = OPEN_CONNECT;
                end else begin
                    emit(HDR_PUBLISH);
                    emit(8'(total - 2));
                    open_kind = OPEN_PUBLISH;
                end
                // first length prefix, high byte always zero for 8-bit lengths
                emit(8'h00);
                emit(first_len);
                field_phase = 1'b0;
                bytes_left  = first_len;
                held_len    = second_len;
                if (first_len == 8'd0)
                    end_first_field();
            end
        end else if (open_kind != OPEN_NONE) begin
            // payload byte copied through
            emit(pay);
            if (bytes_left <= 8'd1) begin
                bytes_left = 8'd0;
                if (field_phase == 1'b0)
                    end_first_field();
                else
                    close_frame();
            end else begin
                bytes_left--;
            end
        end
        foreach (step_bytes[i])
            frame_beats_q.push_back(t_frame_beat'{step_bytes[i],
                step_closed && (i == step_bytes.size() - 1), ERR_NONE});
    endtask

    // compare output first, then predict from the input beat of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_len     = MAX_LEN_RST;
            client_id   = CLIENT_ID_RST;
            open_kind   = OPEN_NONE;
            field_phase = 1'b0;
            bytes_left  = 8'd0;
            held_len    = 8'd0;
            frame_beats_q.delete();
            o_fail_count    = 0;
            o_beats_out     = 0;
            o_error_results = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_beats_out++;
                if (frame_beats_q.size() == 0) begin
                    report($sformatf("output beat %02h with nothing expected", i_m_tdata));
                end else begin
                    head = frame_beats_q.pop_front();
                    if (head.err != ERR_NONE)
                        o_error_results++;
                    if (i_m_tdata !== head.data)
                        report($sformatf("out_byte %02h, expected %02h",
                                         i_m_tdata, head.data));
                    if (i_m_tlast !== head.last)
                        report($sformatf("last %b, expected %b on byte %02h",
                                         i_m_tlast, head.last, head.data));
                    if (i_m_tuser !== head.err)
                        report($sformatf("error %0d, expected %0d",
                                         i_m_tuser, head.err));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_beat(i_s_tuser[0], i_s_tuser[1], i_s_tdata[7:0],
                             i_s_tdata[15:8], i_s_tdata[23:16]);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_MAX_LEN)
                    max_len = i_cfg_data[15:0];
                else
                    client_id = i_cfg_data;
            end
        end
        o_pending <= frame_beats_q.size();
    end

endmodule

FILE: tb/mqtt_packet_framer_tb.sv
`timescale 1ns / 1ps
// testbench top for the mqtt packet framer: reset, stimulus, register phases
// and verdict; depends on mqpf_pkg, mqtt_packet_framer and the stream checker

module mqtt_packet_framer_tb;
    import mqpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;  // first_len, second_len, payload_byte
    logic [S_TUSER_W-1:0] s_tuser;  // req_type, packet_kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;  // out_byte
    logic                 m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;  // error
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [47:0]          cfg_data;

    int fail_count;
    int pending;
    int beats_out;
    int error_results;
    int stall_cycles = 0;
    int beats_in     = 0;
    int starts_in    = 0;
    int cfg_count    = 0;
    int cur_max_len;
    bit no_idle      = 1'b0;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    mqtt_packet_framer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    mqtt_packet_framer_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .i_m_tuser       (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_out     (beats_out),
        .o_error_results (error_results)
    );

    // watchdog: cycles in which no beat moves on any channel
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d beats still due",
                     WATCHDOG_LIMIT, pending);
            $display("mqtt_packet_framer_tb failed");
            $finish;
        end
    end

    // output back-pressure in random bursts, none in the last phase
    initial begin
        @(posedge clk);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // one input beat, with an optional gap in front
    task automatic send_beat(input logic req, input logic kind, input logic [7:0] first_len,
                             input logic [7:0] second_len, input logic [7:0] pay);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pay, second_len, first_len};
        s_tuser  <= {kind, req};
        do @(posedge clk); while (!s_tready);
        beats_in++;
    endtask

    // begin beat followed by n_pay payload beats with random content
    task automatic send_frame(input logic kind, input logic [7:0] first_len,
                              input logic [7:0] second_len, input int n_pay);
        send_beat(REQ_BEGIN, kind, first_len, second_len, 8'($urandom));
        starts_in++;
        for (int i = 0; i < n_pay; i++)
            send_beat(REQ_PAYLOAD, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // mostly whole packets, some cut short or followed by stray payload
    task automatic random_frames(input int n_items);
        int          done;
        int          sel;
        int          total;
        int          n_pay;
        logic        kind;
        logic [7:0]  first_len;
        logic [7:0]  second_len;
        done = 0;
        while (done < n_items) begin
            kind = 1'($urandom);
            sel  = $urandom_range(0, 11);
            if (sel == 0) begin
                first_len  = 8'($urandom);
                second_len = 8'($urandom);
            end else if (sel < 3) begin
                first_len  = 8'($urandom_range(0, 40));
                second_len = 8'($urandom_range(0, 40));
            end else begin
                first_len  = 8'($urandom_range(0, 6));
                second_len = 8'($urandom_range(0, 6));
            end
            total = ((kind == PKT_CONNECT) ? 26 : 4) + first_len + second_len;
            n_pay = (total <= cur_max_len && total - 2 <= 255) ? first_len + second_len : 0;
            sel   = $urandom_range(0, 9);
            if (sel == 0)
                n_pay = $urandom_range(0, n_pay);
            send_frame(kind, first_len, second_len, n_pay);
            done += 1 + n_pay;
            if (sel == 1)
                repeat ($urandom_range(1, 3))
                    send_beat(REQ_PAYLOAD, 1'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom));
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAX_LEN)
            cur_max_len = value[15:0];
        cfg_count++;
    endtask

    // drain every expected beat, then let the block run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_LEN;
        cfg_data  = '0;
        cur_max_len = MAX_LEN_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases at reset settings
        send_frame(PKT_CONNECT, 8'd0, 8'd0, 0);      // all credentials empty
        send_frame(PKT_PUBLISH, 8'd0, 8'd0, 0);      // empty topic and message
        send_frame(PKT_PUBLISH, 8'd1, 8'd1, 0);
        send_beat(REQ_PAYLOAD, PKT_CONNECT, 8'hFF, 8'hFF, 8'h00);
        send_beat(REQ_PAYLOAD, PKT_PUBLISH, 8'h00, 8'h00, 8'hFF);
        send_frame(PKT_CONNECT, 8'd2, 8'd1, 3);
        send_frame(PKT_CONNECT, 8'd0, 8'd2, 2);      // empty username
        send_frame(PKT_PUBLISH, 8'd2, 8'd0, 2);      // empty message
        send_beat(REQ_PAYLOAD, PKT_PUBLISH, 8'h55, 8'hAA, 8'h77);  // no packet open
        send_frame(PKT_CONNECT, 8'd255, 8'd255, 0);  // over max_len
        send_frame(PKT_PUBLISH, 8'd3, 8'd2, 1);      // abandoned by next begin
        send_frame(PKT_PUBLISH, 8'd0, 8'd1, 1);
        settle();

        // widest size limit: remaining length check takes over
        cfg_write(REG_MAX_LEN, 48'hFFFF);
        cfg_write(REG_CLIENT_ID, '1);
        send_frame(PKT_PUBLISH, 8'd255, 8'd255, 0);
        send_frame(PKT_CONNECT, 8'd255, 8'd0, 0);
        send_frame(PKT_PUBLISH, 8'd254, 8'd0, 0);    // remaining length one over
        send_frame(PKT_PUBLISH, 8'd253, 8'd0, 8);    // remaining length exactly 255, cut short
        random_frames(50);
        settle();

        // zero size limit: every begin is refused
        cfg_write(REG_MAX_LEN, 48'h0);
        cfg_write(REG_CLIENT_ID, 48'h0);
        random_frames(20);
        settle();

        // packet size right at the limit and one past it
        cfg_write(REG_MAX_LEN, 48'd40);
        cfg_write(REG_CLIENT_ID, 48'({$urandom, $urandom}));
        send_frame(PKT_CONNECT, 8'd10, 8'd4, 14);
        send_frame(PKT_CONNECT, 8'd10, 8'd5, 0);
        random_frames(50);
        settle();

        cfg_write(REG_MAX_LEN, 48'($urandom_range(0, 600)));
        cfg_write(REG_CLIENT_ID, 48'({$urandom, $urandom}));
        random_frames(60);
        settle();

        // closing phase at full rate on both sides
        no_idle = 1'b1;
        cfg_write(REG_MAX_LEN, 48'(MAX_LEN_RST));
        cfg_write(REG_CLIENT_ID, 48'({$urandom, $urandom}));
        random_frames(50);
        settle();

        $display("sent %0d input beats with %0d packet starts over %0d register writes",
                 beats_in, starts_in, cfg_count);
        $display("checked %0d output beats, %0d of them size errors", beats_out, error_results);
        if (fail_count == 0)
            $display("mqtt_packet_framer_tb passed");
        else
            $display("mqtt_packet_framer_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/mqpf_pkg.sv
sv/mqpf_fifo.sv
sv/mqpf_front.sv
sv/mqpf_back.sv
sv/mqtt_packet_framer.sv
tb/mqtt_packet_framer_checker.sv
tb/mqtt_packet_framer_tb.sv
